@@ hw/rtl/hs_pkg.sv @@
`timescale 1ns / 1ps
// hs_pkg: shared types and constants of the heap sorter.
// Used by hs_ctrl, hs_datapath, heap_sorter_unit and tb; depends on nothing.
package hs_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_BLD_INIT,
        ST_BLD_CHK,
        ST_BLD_RD,
        ST_BLD_CUR,
        ST_SIFT_L,
        ST_SIFT_R,
        ST_SIFT_C,
        ST_EX_INIT,
        ST_EX_CHK,
        ST_EX_RD0,
        ST_EX_RDK,
        ST_EX_SW,
        ST_OUT_INIT,
        ST_OUT_RD,
        ST_OUT_LD
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_BLD_INIT,
        OP_BLD_RD,
        OP_LD_CUR,
        OP_SIFT_L,
        OP_SIFT_R,
        OP_SIFT_C,
        OP_EX_INIT,
        OP_EX_RD0,
        OP_EX_RDK,
        OP_EX_SW,
        OP_OUT_INIT,
        OP_OUT_RD,
        OP_OUT_LD
    } t_dp_op;

    typedef struct packed {
        logic k_zero;
        logic k_le1;
        logic left_ok;
        logic stay;
        logic out_free;
        logic out_last;
    } t_dp_status;

endpackage

@@ hw/rtl/heap_sorter_unit.sv @@
`timescale 1ns / 1ps
// heap_sorter_unit: top level of the heap sorter.
// Depends on hs_pkg, hs_ctrl and hs_datapath.
//
// Collects up to MAX_ITEMS signed 32-bit values, one request per cycle; the
// request with tlast closes the set (values arriving with the store full are
// dropped and tuser is raised on every result of that set). The set is then
// heap-sorted in place in a single-port-read store and streamed out in
// ascending order, tlast marking the largest. Sorting holds off input: each
// sift level is two child reads and a compare/write on the one read port,
// each heap build node has a setup of check, node read and node load, each
// extraction a setup of check, root read, last-element read and swap, and
// each result a read and a load of the output register.
module heap_sorter_unit
    import hs_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] value
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] sorted_value
    output logic              m_axis_tlast,
    output logic              m_axis_tuser    // [0] overflowed
);

    t_dp_op     w_op;
    t_dp_status w_status;

    hs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready),
        .o_op       (w_op)
    );

    hs_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op),
        .i_value     ($signed(s_axis_tdata)),
        .i_out_ready (m_axis_tready),
        .o_status    (w_status),
        .o_out_data  (m_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .o_out_last  (m_axis_tlast),
        .o_out_ovf   (m_axis_tuser)
    );

endmodule

@@ hw/rtl/hs_ctrl.sv @@
`timescale 1ns / 1ps
// hs_ctrl: sequencer of the heap sorter (load, heap build, extraction, drain).
// Depends on hs_pkg; drives hs_datapath through one op code per cycle.
module hs_ctrl
    import hs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_last,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_op     o_op
);

    t_state r_state, n_state;
    logic   r_extract, n_extract;
    logic   w_accept;

    assign w_accept = i_in_valid && (r_state == ST_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_extract <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_extract <= n_extract;
        end
    end

    // next state
    always_comb begin
        n_state   = r_state;
        n_extract = r_extract;
        case (r_state)
            ST_LOAD: begin
                if (w_accept && i_in_last) n_state = ST_BLD_INIT;
            end
            ST_BLD_INIT: begin
                n_extract = 1'b0;
                n_state   = ST_BLD_CHK;
            end
            ST_BLD_CHK: begin
                n_state = i_status.k_zero ? ST_EX_INIT : ST_BLD_RD;
            end
            ST_BLD_RD:  n_state = ST_BLD_CUR;
            ST_BLD_CUR: n_state = ST_SIFT_L;
            ST_SIFT_L: begin
                if (!i_status.left_ok) n_state = r_extract ? ST_EX_CHK : ST_BLD_CHK;
                else                   n_state = ST_SIFT_R;
            end
            ST_SIFT_R: n_state = ST_SIFT_C;
            ST_SIFT_C: begin
                if (i_status.stay) n_state = r_extract ? ST_EX_CHK : ST_BLD_CHK;
                else               n_state = ST_SIFT_L;
            end
            ST_EX_INIT: begin
                n_extract = 1'b1;
                n_state   = ST_EX_CHK;
            end
            ST_EX_CHK: begin
                n_state = i_status.k_le1 ? ST_OUT_INIT : ST_EX_RD0;
            end
            ST_EX_RD0:   n_state = ST_EX_RDK;
            ST_EX_RDK:   n_state = ST_EX_SW;
            ST_EX_SW:    n_state = ST_SIFT_L;
            ST_OUT_INIT: n_state = ST_OUT_RD;
            ST_OUT_RD:   n_state = ST_OUT_LD;
            ST_OUT_LD: begin
                if (i_status.out_free) n_state = i_status.out_last ? ST_LOAD : ST_OUT_RD;
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_op       = OP_NONE;
        case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                o_op       = w_accept ? OP_LOAD : OP_NONE;
            end
            ST_BLD_INIT: o_op = OP_BLD_INIT;
            ST_BLD_CHK:  o_op = OP_NONE;
            ST_BLD_RD:   o_op = OP_BLD_RD;
            ST_BLD_CUR:  o_op = OP_LD_CUR;
            ST_SIFT_L:   o_op = OP_SIFT_L;
            ST_SIFT_R:   o_op = OP_SIFT_R;
            ST_SIFT_C:   o_op = OP_SIFT_C;
            ST_EX_INIT:  o_op = OP_EX_INIT;
            ST_EX_CHK:   o_op = OP_NONE;
            ST_EX_RD0:   o_op = OP_EX_RD0;
            ST_EX_RDK:   o_op = OP_EX_RDK;
            ST_EX_SW:    o_op = OP_EX_SW;
            ST_OUT_INIT: o_op = OP_OUT_INIT;
            ST_OUT_RD:   o_op = OP_OUT_RD;
            ST_OUT_LD:   o_op = i_status.out_free ? OP_OUT_LD : OP_NONE;
            default:     o_op = OP_NONE;
        endcase
    end

    // a closing request always starts a heap build
    a_close_builds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_last) |=> (r_state == ST_BLD_INIT))
        else $error("closing request did not start the sort");

    // no request is taken in the sift compare or output load states
    a_ready_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SIFT_C || r_state == ST_OUT_LD) |-> !o_in_ready)
        else $error("input ready while sorting or draining");

    // extraction phase is never left for the build loop when a sift reaches a leaf
    a_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_extract && r_state == ST_SIFT_L && !i_status.left_ok) |=>
        (r_state == ST_EX_CHK))
        else $error("sift return lost extraction phase");

endmodule

@@ hw/rtl/hs_datapath.sv @@
`timescale 1ns / 1ps
// hs_datapath: element store, heap index/counter registers, sift compare and
// output register of the heap sorter. Depends on hs_pkg; commanded by hs_ctrl.
module hs_datapath
    import hs_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_op                   i_op,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_out_ready,
    output t_dp_status               o_status,
    output logic        [DATA_W-1:0] o_out_data,
    output logic                     o_out_valid,
    output logic                     o_out_last,
    output logic                     o_out_ovf
);

    localparam int AW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW  = $clog2(MAX_ITEMS + 1);
    localparam int CHW = AW + 2;

    logic signed [DATA_W-1:0] r_mem [MAX_ITEMS];
    logic signed [DATA_W-1:0] r_rd_data;
    logic signed [DATA_W-1:0] r_cur;
    logic signed [DATA_W-1:0] r_lval;
    logic signed [DATA_W-1:0] r_a0;
    logic        [CW-1:0]     r_count;
    logic                     r_ovf;
    logic        [CW-1:0]     r_k;
    logic        [CW-1:0]     r_size;
    logic        [AW-1:0]     r_at;
    logic        [AW-1:0]     r_idx;
    logic                     r_out_valid;
    logic        [DATA_W-1:0] r_out_data;
    logic                     r_out_last;
    logic                     r_out_ovf;

    logic        [CW-1:0]     w_km1;
    logic        [CW-1:0]     w_cnt_m1;
    logic        [CHW-1:0]    w_left;
    logic        [CHW-1:0]    w_right;
    logic                     w_left_ok;
    logic                     w_right_ok;
    logic signed [DATA_W-1:0] w_best;
    logic        [AW-1:0]     w_sel;
    logic                     w_stay;
    logic                     w_full;
    logic                     w_out_last;
    logic                     w_we;
    logic        [AW-1:0]     w_waddr;
    logic signed [DATA_W-1:0] w_wdata;
    logic                     w_re;
    logic        [AW-1:0]     w_raddr;

    assign w_km1      = r_k - CW'(1);
    assign w_cnt_m1   = r_count - CW'(1);
    assign w_left     = CHW'({r_at, 1'b1});
    assign w_right    = w_left + CHW'(1);
    assign w_left_ok  = w_left < CHW'(r_size);
    assign w_right_ok = w_right < CHW'(r_size);
    assign w_full     = (r_count == CW'(MAX_ITEMS));
    assign w_out_last = (CW'(r_idx) == w_cnt_m1);

    // largest of node and children; right child data is on the read port
    always_comb begin
        w_best = r_cur;
        w_sel  = r_at;
        w_stay = 1'b1;
        if (w_left_ok && (r_lval > r_cur)) begin
            w_best = r_lval;
            w_sel  = w_left[AW-1:0];
            w_stay = 1'b0;
        end
        if (w_right_ok && (r_rd_data > w_best)) begin
            w_best = r_rd_data;
            w_sel  = w_right[AW-1:0];
            w_stay = 1'b0;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_at;
        w_wdata = w_best;
        w_re    = 1'b0;
        w_raddr = r_at;
        case (i_op)
            OP_LOAD: begin
                w_we    = !w_full;
                w_waddr = r_count[AW-1:0];
                w_wdata = i_value;
            end
            OP_BLD_RD: begin
                w_re    = 1'b1;
                w_raddr = w_km1[AW-1:0];
            end
            OP_SIFT_L: begin
                w_we    = !w_left_ok;
                w_wdata = r_cur;
                w_re    = w_left_ok;
                w_raddr = w_left[AW-1:0];
            end
            OP_SIFT_R: begin
                w_re    = 1'b1;
                w_raddr = w_right[AW-1:0];
            end
            OP_SIFT_C: begin
                w_we    = 1'b1;
                w_wdata = w_best;
            end
            OP_EX_RD0: begin
                w_re    = 1'b1;
                w_raddr = '0;
            end
            OP_EX_RDK: begin
                w_re    = 1'b1;
                w_raddr = w_km1[AW-1:0];
            end
            OP_EX_SW: begin
                w_we    = 1'b1;
                w_waddr = w_km1[AW-1:0];
                w_wdata = r_a0;
            end
            OP_OUT_RD: begin
                w_re    = 1'b1;
                w_raddr = r_idx;
            end
            default: begin
                w_we = 1'b0;
                w_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (w_re) r_rd_data <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_op == OP_LOAD) begin
                if (w_full) r_ovf   <= 1'b1;
                else        r_count <= r_count + CW'(1);
            end else if (i_op == OP_OUT_LD && w_out_last) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
            if (i_op == OP_OUT_LD) r_out_valid <= 1'b1;
            else if (i_out_ready)  r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_BLD_INIT: begin
                r_k    <= r_count >> 1;
                r_size <= r_count;
            end
            OP_BLD_RD: begin
                r_at <= w_km1[AW-1:0];
                r_k  <= w_km1;
            end
            OP_LD_CUR: r_cur  <= r_rd_data;
            OP_SIFT_R: r_lval <= r_rd_data;
            OP_SIFT_C: r_at   <= w_sel;
            OP_EX_INIT: r_k   <= r_count;
            OP_EX_RDK: r_a0   <= r_rd_data;
            OP_EX_SW: begin
                r_cur  <= r_rd_data;
                r_at   <= '0;
                r_size <= w_km1;
                r_k    <= w_km1;
            end
            OP_OUT_INIT: r_idx <= '0;
            OP_OUT_LD: begin
                r_idx      <= r_idx + AW'(1);
                r_out_data <= r_rd_data;
                r_out_last <= w_out_last;
                r_out_ovf  <= r_ovf;
            end
            default: r_idx <= r_idx;
        endcase
    end

    assign o_status.k_zero   = (r_k == '0);
    assign o_status.k_le1    = (r_k <= CW'(1));
    assign o_status.left_ok  = w_left_ok;
    assign o_status.stay     = w_stay;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.out_last = w_out_last;

    assign o_out_data  = r_out_data;
    assign o_out_valid = r_out_valid;
    assign o_out_last  = r_out_last;
    assign o_out_ovf   = r_out_ovf;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ITEMS))
        else $error("element count beyond capacity");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> w_full)
        else $error("overflow flagged with free store");

    a_sift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_SIFT_C || i_op == OP_SIFT_L) |-> (CW'(r_at) < r_size))
        else $error("sift node outside heap");

    a_set_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_OUT_LD && w_out_last) |=> (r_count == '0 && !r_ovf))
        else $error("set state not cleared after last result");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking testbench of heap_sorter_unit.
// Depends on hs_pkg and the heap sorter RTL; sends sets of values, checks the sorted stream.
module tb
    import hs_pkg::*;
();

    localparam int CAP         = MAX_ITEMS_DEF;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 4000;
    localparam int DRAIN_WAIT  = 100;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
        logic              ovf;
    } t_sorted_rec;

    // Own heap sort of the collected set; expected results queued per closed set.
    class t_sort_scoreboard;
        logic signed [DATA_W-1:0] held [CAP];
        int          held_cnt   = 0;
        bit          dropped    = 0;
        t_sorted_rec expected_q[$];
        int          mismatches = 0;
        int          results    = 0;
        int          requests   = 0;
        int          sets       = 0;
        int          ovf_sets   = 0;

        function void sift(int size, int start);
            int at;
            int top;
            int lc;
            int rc;
            bit done;
            logic signed [DATA_W-1:0] t;
            at   = start;
            done = 0;
            while (!done) begin
                top = at;
                lc  = 2 * at + 1;
                rc  = 2 * at + 2;
                if (lc < size && held[lc] > held[top]) top = lc;
                if (rc < size && held[rc] > held[top]) top = rc;
                if (top == at) begin
                    done = 1;
                end else begin
                    t         = held[at];
                    held[at]  = held[top];
                    held[top] = t;
                    at        = top;
                end
            end
        endfunction

        function void note_request(logic [DATA_W-1:0] v, logic last);
            int k;
            t_sorted_rec rec;
            logic signed [DATA_W-1:0] t;
            requests++;
            if (held_cnt < CAP) begin
                held[held_cnt] = v;
                held_cnt++;
            end else begin
                dropped = 1;
            end
            if (!last) return;
            for (k = held_cnt / 2; k > 0; k--) sift(held_cnt, k - 1);
            for (k = held_cnt; k > 1; k--) begin
                t           = held[0];
                held[0]     = held[k - 1];
                held[k - 1] = t;
                sift(k - 1, 0);
            end
            for (k = 0; k < held_cnt; k++) begin
                rec.value = held[k];
                rec.last  = (k == held_cnt - 1);
                rec.ovf   = dropped;
                expected_q.push_back(rec);
            end
            sets++;
            if (dropped) ovf_sets++;
            held_cnt = 0;
            dropped  = 0;
        endfunction

        function void check_result(logic [DATA_W-1:0] v, logic last, logic ovf);
            t_sorted_rec want;
            results++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result value=%0d last=%b ovf=%b",
                             $time, $signed(v), last, ovf);
                return;
            end
            want = expected_q.pop_front();
            if (want.value !== v || want.last !== last || want.ovf !== ovf) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch exp value=%0d last=%b ovf=%b,",
                             $time, $signed(want.value), want.last, want.ovf,
                             " got value=%0d last=%b ovf=%b",
                             $signed(v), last, ovf);
            end
        endfunction
    endclass

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata  = '0;   // [31:0] value
    logic              s_axis_tlast  = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;         // [31:0] sorted_value
    logic              m_axis_tlast;
    logic              m_axis_tuser;         // [0] overflowed

    t_sort_scoreboard sb;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold_cnt  = 0;
    int quiet_cycles = 0;

    heap_sorter_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off while rx_hold_cnt runs down
    always @(posedge i_clk) begin
        if (rx_hold_cnt > 0) begin
            rx_hold_cnt = rx_hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: timeout, no request moved for %0d cycles", $time, quiet_cycles);
                $display("** heap_sorter_unit: FAILED **");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [DATA_W-1:0] v, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(v, last);
    endtask

    function automatic logic [DATA_W-1:0] pick_value(int style);
        case (style)
            0: return $urandom;
            1: return DATA_W'($urandom_range(16)) - DATA_W'(8);   // many repeats
            default: begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return '0;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    task automatic send_set(input int n, input int style);
        int i;
        for (i = 0; i < n; i++) send_item(pick_value(style), i == n - 1);
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input int items);
        int sent;
        int n;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        sent         = 0;
        while (sent < items) begin
            n = ($urandom_range(7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            send_set(n, $urandom_range(2));
            sent += n;
        end
    endtask

    initial begin
        logic [DATA_W-1:0] extremes [7];
        int i;
        extremes = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1,
                     32'h8000_0000, 32'h7FFF_FFFF};
        sb = new;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: one-value set, extremes with repeats, all-equal, descending, pair
        send_item(32'h7FFF_FFFF, 1'b1);
        for (i = 0; i < 7; i++) send_item(extremes[i], i == 6);
        for (i = 0; i < 4; i++) send_item(32'd5, i == 3);
        for (i = 6; i > 0; i--) send_item(DATA_W'(i * 7 - 20), i == 1);
        send_item(-32'sd3, 1'b0);
        send_item(32'sd3, 1'b1);

        // random sets under the idle/stall mixes; full store with one value dropped
        run_phase(0, 0, 12);
        run_phase(88, 0, 12);
        run_phase(0, 88, 12);
        send_set(CAP + 1, 2);
        run_phase(18, 18, 12);

        // receiver holds off while sets keep coming, so input backs up
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_cnt  = HOLD_CYCLES;
        for (i = 0; i < 4; i++) send_set(4, $urandom_range(2));
        s_axis_tvalid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("run: %0d requests in %0d sets (%0d overflowed), %0d results checked",
                 sb.requests, sb.sets, sb.ovf_sets, sb.results);
        $display("run: full and overflowing store, equal and extreme values, idle/stall mixes");
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("** heap_sorter_unit: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.expected_q.size());
            $display("** heap_sorter_unit: FAILED **");
        end
        $finish;
    end

endmodule
